FILE: hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int VAL_W = 32;
	localparam int LVL_W = 3;
	localparam int OCC_W = 5;

	// number of priority levels, level 0 is served first
	localparam int PRIO_LEVELS = 6;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef struct packed {
		logic                    cmd;
		logic signed [VAL_W-1:0] item_value;
		logic [LVL_W-1:0]        item_priority;
	} req_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] out_value;
		logic [OCC_W-1:0]        occupancy;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic      load;
		logic      push;
		logic      pop;
		status_e_t status;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage

FILE: hw/rtl/spq_ctrl.sv
module spq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_cmd,
	output logic                  req_stall,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  spq_pkg::dp_status_t   status,
	output spq_pkg::ctl_cmd_t     cmd
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   load;

	// result register frees up in the same cycle it is taken
	assign req_stall = (state_q == S_HOLD) && rsp_stall;
	assign rsp_valid = (state_q == S_HOLD);
	assign load      = req_valid && !req_stall;

	always_comb begin
		cmd.load = load;
		cmd.push = load && (req_cmd == spq_pkg::CMD_ENQ) && !status.full;
		cmd.pop  = load && (req_cmd == spq_pkg::CMD_DEQ) && !status.empty;
		priority if ((req_cmd == spq_pkg::CMD_ENQ) && status.full) begin
			cmd.status = spq_pkg::ST_FULL;
		end else if ((req_cmd == spq_pkg::CMD_DEQ) && status.empty) begin
			cmd.status = spq_pkg::ST_EMPTY;
		end else begin
			cmd.status = spq_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (load) begin
						state_q <= S_HOLD;
					end else if (!rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/spq_datapath.sv
module spq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  spq_pkg::ctl_cmd_t                       cmd,
	input  logic signed [spq_pkg::VAL_W-1:0]        item_value,
	input  logic [spq_pkg::LVL_W-1:0]               item_priority,
	output spq_pkg::dp_status_t                     status,
	output spq_pkg::rsp_t                           rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                 cnt_q;
	logic [CNT_W-1:0]                 cnt_d;
	logic signed [spq_pkg::VAL_W-1:0] val_q [DEPTH];
	logic [spq_pkg::LVL_W-1:0]        lvl_q [DEPTH];
	logic [spq_pkg::LVL_W-1:0]        new_lvl;
	logic [DEPTH-1:0]                 gt;
	spq_pkg::rsp_t                    rsp_q;

	// out-of-range levels saturate to the lowest priority
	always_comb begin
		if (32'(item_priority) >= 32'(spq_pkg::PRIO_LEVELS)) begin
			new_lvl = spq_pkg::LVL_W'(spq_pkg::PRIO_LEVELS - 1);
		end else begin
			new_lvl = item_priority;
		end
	end

	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);

	always_comb begin
		priority if (cmd.push) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                             prev_gt;
			logic signed [spq_pkg::VAL_W-1:0] prev_val;
			logic [spq_pkg::LVL_W-1:0]        prev_lvl;
			logic signed [spq_pkg::VAL_W-1:0] next_val;
			logic [spq_pkg::LVL_W-1:0]        next_lvl;

			// stored entry outranked by the new item: it moves back
			assign gt[i] = (CNT_W'(i) < cnt_q) && (lvl_q[i] > new_lvl);

			if (i == 0) begin : g_head
				assign prev_gt  = 1'b0;
				assign prev_val = val_q[0];
				assign prev_lvl = lvl_q[0];
			end else begin : g_body
				assign prev_gt  = gt[i-1];
				assign prev_val = val_q[i-1];
				assign prev_lvl = lvl_q[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign next_val = val_q[i];
				assign next_lvl = lvl_q[i];
			end else begin : g_mid
				assign next_val = val_q[i+1];
				assign next_lvl = lvl_q[i+1];
			end

			always_ff @(posedge clk) begin
				if (cmd.push) begin
					if (prev_gt) begin
						val_q[i] <= prev_val;
						lvl_q[i] <= prev_lvl;
					end else if (gt[i] || (CNT_W'(i) == cnt_q)) begin
						val_q[i] <= item_value;
						lvl_q[i] <= new_lvl;
					end
				end else if (cmd.pop) begin
					val_q[i] <= next_val;
					lvl_q[i] <= next_lvl;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status    <= cmd.status;
			rsp_q.out_value <= cmd.pop ? val_q[0] : '0;
			rsp_q.occupancy <= spq_pkg::OCC_W'(cnt_d);
		end
	end

	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
		else $error("enqueue did not grow the store");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !status.full && !cmd.pop)
		else $error("enqueue into full store");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) |-> lvl_q[0] <= lvl_q[1])
		else $error("head entry out of priority order");
`endif

endmodule

FILE: hw/rtl/stable_priority_queue_unit.sv
// stable priority queue of signed 32-bit values with levels 0..5
//
// req channel (req_valid / req_stall / req): cmd 0 enqueues item_value at
// item_priority, cmd 1 dequeues the head; an item is accepted on a clock
// edge with req_valid high and req_stall low
// rsp channel (rsp_valid / rsp_stall / rsp): one result item per request,
// carrying status (ok, empty, full), the dequeued value and the occupancy
// after the step
//
// the result is registered and valid in the cycle after acceptance; the
// unit takes one item per cycle while rsp_stall is low, set by the row of
// DEPTH sorted cells that inserts in place and shifts out the head
// a held result does not block the next request unless rsp_stall is high;
// while the receiver stalls a full result register, req_stall follows
// rsp_stall and the held result stays unchanged
//
// reset clears the occupancy count and the result valid; stored entries
// are not cleared, they are only read once written
module stable_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::ctl_cmd_t   cmd;
	spq_pkg::dp_status_t status;

	// handshake control and status decode
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// sorted cell row, occupancy count and result register
	spq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_value    (req.item_value),
		.item_priority (req.item_priority),
		.status        (status),
		.rsp           (rsp)
	);

endmodule
